@@ sv/ptpc_pkg.sv @@
// Shared constants, types and register codes for the pulse trace peak/charge/trigger block.
// No dependencies; every other file uses this package.
package ptpc_pkg;

  localparam int BINS_PER_RECORD = 69;
  localparam int STRETCH_BINS    = 3;
  localparam int NUM_CH          = 4;
  localparam int NUM_STRETCH     = 3;
  localparam int POS_W           = 7;
  localparam int SAMPLE_W        = 12;
  localparam int CHARGE_W        = 19;
  localparam int WIN_W           = 14;
  localparam int STRETCH_W       = 2;
  localparam int TAG_W           = 31;
  localparam int TYPE_W          = 4;
  localparam int CH_W            = 2;
  localparam int WORD_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 14;

  // header field positions
  localparam int FLAG_BIT  = 31;
  localparam int CALIB_BIT = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_CH0    = 3'd0,
    REG_WINDOW_CH1    = 3'd1,
    REG_WINDOW_CH2    = 3'd2,
    REG_WINDOW_CH3    = 3'd3,
    REG_THRESHOLD_CH0 = 3'd4,
    REG_THRESHOLD_CH1 = 3'd5,
    REG_THRESHOLD_CH2 = 3'd6
  } reg_idx_t;

  localparam logic [WIN_W-1:0]    WINDOW_RST_WIDE = 14'd8960;
  localparam logic [WIN_W-1:0]    WINDOW_RST_CH3  = 14'd4495;
  localparam logic [SAMPLE_W-1:0] THRESH_RST_CH0  = 12'h120;
  localparam logic [SAMPLE_W-1:0] THRESH_RST_CH1  = 12'h105;
  localparam logic [SAMPLE_W-1:0] THRESH_RST_CH2  = 12'h106;

  // per-beat control broadcast to all lanes
  typedef struct packed {
    logic             bin_en;
    logic [POS_W-1:0] bin;
    logic             hdr_clr;
  } lane_ctl_t;

  // what one lane found over a record
  typedef struct packed {
    logic [SAMPLE_W-1:0] peak;
    logic [CHARGE_W-1:0] charge;
    logic [POS_W-1:0]    peak_bin;
    logic [SAMPLE_W-1:0] baseline;
  } lane_res_t;

  // record-wide info captured at the header and during the bins
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TYPE_W-1:0] trig;
    logic              calib;
    logic              coinc;
    logic              ferr;
  } rec_info_t;

endpackage

@@ sv/ptpc_in_if.sv @@
// Input channel: one beat carries one word pair of a record.
// Depends on ptpc_pkg.
interface ptpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptpc_pkg::WORD_W-1:0]   word_a;
  logic [ptpc_pkg::WORD_W-1:0]   word_b;

  modport source (output valid, output word_a, output word_b, input ready);
  modport sink   (input valid, input word_a, input word_b, output ready);
endinterface

@@ sv/ptpc_out_if.sv @@
// Output channel: one beat carries one per-channel result.
// Depends on ptpc_pkg.
interface ptpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [ptpc_pkg::CH_W-1:0]       channel;
  logic [ptpc_pkg::SAMPLE_W-1:0]   peak;
  logic [ptpc_pkg::CHARGE_W-1:0]   charge;
  logic [ptpc_pkg::POS_W-1:0]      peak_bin;
  logic [ptpc_pkg::SAMPLE_W-1:0]   baseline;
  logic [ptpc_pkg::TAG_W-1:0]      time_tag;
  logic [ptpc_pkg::TYPE_W-1:0]     trigger_type;
  logic                            calib_flag;
  logic                            coincidence;
  logic                            status;
  logic                            last;

  modport source (output valid, output channel, output peak, output charge, output peak_bin,
                  output baseline, output time_tag, output trigger_type, output calib_flag,
                  output coincidence, output status, output last, input ready);
  modport sink   (input valid, input channel, input peak, input charge, input peak_bin,
                  input baseline, input time_tag, input trigger_type, input calib_flag,
                  input coincidence, input status, input last, output ready);
endinterface

@@ sv/pulse_trace_peak_charge_trigger_top.sv @@
// Pulse trace peak/charge/trigger: one word pair per beat, 70 beats per record.
// Throughput: one pair per cycle but for the stall below; the 4 result beats leave
// one per cycle while the sink is ready. The final bin stalls only while the
// previous record's results are still undelivered (the 4-entry result snapshot).
// Reset (sync, active high) clears position, flags and lane state; config to defaults.
module pulse_trace_peak_charge_trigger_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ptpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptpc_pkg::CFG_DATA_W-1:0] cfg_data,
  ptpc_in_if.sink                         pairs,
  ptpc_out_if.source                      results
);
  import ptpc_pkg::*;

  // configuration registers
  logic [WIN_W-1:0]    window    [NUM_CH];
  logic [SAMPLE_W-1:0] threshold [NUM_CH];

  // record sequencing
  logic [POS_W-1:0]    pos;
  logic                ferr;
  logic                coinc;
  logic [TAG_W-1:0]    hdr_tag;
  logic [TYPE_W-1:0]   hdr_type;
  logic                hdr_calib;
  logic                snap_load;

  logic                accept;
  logic                is_hdr;
  logic                last_bin;
  logic                bad_bin;
  logic                hdr_ok;
  logic                busy;
  lane_ctl_t           ctl;
  lane_res_t           lane_res [NUM_CH];
  logic [NUM_CH-1:0]   lane_act;
  logic [SAMPLE_W-1:0] samples  [NUM_CH];
  rec_info_t           info;

  // ---------------------------------------------------------------------------
  // Config write port; unknown indexes are dropped. Channel 3 has no threshold,
  // its slot stays at zero and the lane ignores it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window[0]    <= WINDOW_RST_WIDE;
      window[1]    <= WINDOW_RST_WIDE;
      window[2]    <= WINDOW_RST_WIDE;
      window[3]    <= WINDOW_RST_CH3;
      threshold[0] <= THRESH_RST_CH0;
      threshold[1] <= THRESH_RST_CH1;
      threshold[2] <= THRESH_RST_CH2;
      threshold[3] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW_CH0:    window[0]    <= cfg_data;
        REG_WINDOW_CH1:    window[1]    <= cfg_data;
        REG_WINDOW_CH2:    window[2]    <= cfg_data;
        REG_WINDOW_CH3:    window[3]    <= cfg_data;
        REG_THRESHOLD_CH0: threshold[0] <= cfg_data[SAMPLE_W-1:0];
        REG_THRESHOLD_CH1: threshold[1] <= cfg_data[SAMPLE_W-1:0];
        REG_THRESHOLD_CH2: threshold[2] <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Beat decode. pos 0 expects the header, pos p carries bin p-1.
  // ---------------------------------------------------------------------------
  assign is_hdr   = (pos == '0);
  assign last_bin = (pos == POS_W'(BINS_PER_RECORD));
  assign bad_bin  = pairs.word_a[FLAG_BIT] || pairs.word_b[FLAG_BIT];
  assign hdr_ok   = pairs.word_a[FLAG_BIT] && pairs.word_b[FLAG_BIT];

  // Hold the final bin back until the result stage has room for the snapshot.
  assign pairs.ready = !(last_bin && (busy || snap_load));
  assign accept      = pairs.valid && pairs.ready;

  assign ctl.bin     = pos - 1'b1;
  assign ctl.bin_en  = accept && !is_hdr && !ferr && !bad_bin;
  assign ctl.hdr_clr = accept && is_hdr;

  assign samples[0] = pairs.word_a[SAMPLE_W-1:0];
  assign samples[1] = pairs.word_a[16+SAMPLE_W-1:16];
  assign samples[2] = pairs.word_b[SAMPLE_W-1:0];
  assign samples[3] = pairs.word_b[16+SAMPLE_W-1:16];

  // ---------------------------------------------------------------------------
  // Lanes: one per channel, all fed the same control each beat.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    ptpc_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sample     (samples[g]),
      .window     (window[g]),
      .threshold  (threshold[g]),
      .stretch_on (1'(g < NUM_STRETCH)),
      .res        (lane_res[g]),
      .active     (lane_act[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer: position, format error, header capture, coincidence.
  // A record with an error still runs its full length; later beats are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ferr      <= 1'b0;
      coinc     <= 1'b0;
      hdr_tag   <= '0;
      hdr_type  <= '0;
      hdr_calib <= 1'b0;
      snap_load <= 1'b0;
    end else begin
      snap_load <= accept && last_bin;
      if (accept) begin
        if (is_hdr) begin
          ferr  <= !hdr_ok;
          coinc <= 1'b0;
          if (hdr_ok) begin
            hdr_tag   <= pairs.word_a[TAG_W-1:0];
            hdr_type  <= pairs.word_b[TYPE_W-1:0];
            hdr_calib <= pairs.word_b[CALIB_BIT];
          end
          pos <= POS_W'(1);
        end else begin
          if (!ferr && bad_bin) begin
            ferr <= 1'b1;
          end
          // all three stretched channels active in the same bin
          if (ctl.bin_en && (&lane_act[NUM_STRETCH-1:0])) begin
            coinc <= 1'b1;
          end
          pos <= last_bin ? '0 : pos + 1'b1;
        end
      end
    end
  end

  // Snapshot is taken the cycle after the final bin; a header accepted in that
  // same cycle only changes these registers after the snapshot edge.
  assign info.tag   = hdr_tag;
  assign info.trig  = hdr_type;
  assign info.calib = hdr_calib;
  assign info.coinc = coinc;
  assign info.ferr  = ferr;

  ptpc_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (snap_load),
    .lanes   (lane_res),
    .info    (info),
    .busy    (busy),
    .results (results)
  );

endmodule

@@ sv/ptpc_lane.sv @@
// One channel lane: baseline, peak, peak bin, windowed charge and threshold stretch.
// Depends on ptpc_pkg.
module ptpc_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  ptpc_pkg::lane_ctl_t           ctl,
  input  logic [ptpc_pkg::SAMPLE_W-1:0] sample,
  input  logic [ptpc_pkg::WIN_W-1:0]    window,
  input  logic [ptpc_pkg::SAMPLE_W-1:0] threshold,
  input  logic                          stretch_on,
  output ptpc_pkg::lane_res_t           res,
  output logic                          active
);
  import ptpc_pkg::*;

  logic [POS_W-1:0]     win_lo;
  logic [POS_W-1:0]     win_hi;
  logic                 in_win;
  logic                 first_bin;
  logic                 above;
  logic [STRETCH_W-1:0] cnt;
  logic [CHARGE_W-1:0]  sample_ext;

  assign win_lo     = window[POS_W-1:0];
  assign win_hi     = window[2*POS_W-1:POS_W];
  assign in_win     = (win_lo <= ctl.bin) && (ctl.bin < win_hi);
  assign first_bin  = (ctl.bin == '0);
  assign above      = (sample > threshold);
  assign sample_ext = CHARGE_W'(sample);
  assign active     = stretch_on && !first_bin && (above || (cnt != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
      cnt <= '0;
    end else begin
      if (ctl.hdr_clr) begin
        cnt <= '0;
      end
      if (ctl.bin_en) begin
        if (first_bin) begin
          res.baseline <= sample;
          res.peak     <= sample;
          res.peak_bin <= '0;
          res.charge   <= in_win ? sample_ext : '0;
        end else begin
          if (res.peak < sample) begin
            res.peak     <= sample;
            res.peak_bin <= ctl.bin;
          end
          if (in_win) begin
            res.charge <= res.charge + sample_ext;
          end
          if (stretch_on) begin
            if (above) begin
              cnt <= STRETCH_W'(STRETCH_BINS);
            end else if (cnt != '0) begin
              cnt <= cnt - 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

@@ sv/ptpc_merge.sv @@
// Result stage: snapshots the four lanes at record end and plays them out as four beats.
// Depends on ptpc_pkg and ptpc_out_if.
module ptpc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ptpc_pkg::lane_res_t lanes [ptpc_pkg::NUM_CH],
  input  ptpc_pkg::rec_info_t info,
  output logic                busy,
  ptpc_out_if.source          results
);
  import ptpc_pkg::*;

  lane_res_t        snap [NUM_CH];
  rec_info_t        snap_info;
  logic [CH_W-1:0]  idx;
  logic             pending;
  logic             beat;
  lane_res_t        cur;

  assign beat = results.valid && results.ready;
  assign busy = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      pending <= 1'b1;
      idx     <= '0;
    end else if (beat) begin
      idx <= idx + 1'b1;
      if (idx == CH_W'(NUM_CH - 1)) begin
        pending <= 1'b0;
      end
    end
  end

  // error records report zeros except channel, status and last
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        snap[i] <= info.ferr ? '0 : lanes[i];
      end
      snap_info <= info.ferr ? rec_info_t'{ferr: 1'b1, default: '0} : info;
    end
  end

  assign cur = snap[idx];

  always_comb begin
    results.valid        = pending;
    results.channel      = idx;
    results.peak         = cur.peak;
    results.charge       = cur.charge;
    results.peak_bin     = cur.peak_bin;
    results.baseline     = cur.baseline;
    results.time_tag     = snap_info.tag;
    results.trigger_type = snap_info.trig;
    results.calib_flag   = snap_info.calib;
    results.coincidence  = snap_info.coinc;
    results.status       = snap_info.ferr;
    results.last         = (idx == CH_W'(NUM_CH - 1));
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for pulse_trace_peak_charge_trigger_top: streams records of word pairs and
// checks each per-channel summary beat against an in-bench model of the record logic.
// Depends on ptpc_pkg, ptpc_in_if and ptpc_out_if.
module tb;
  import ptpc_pkg::*;

  localparam int RECORD_LEN     = BINS_PER_RECORD + 1;  // header + bins
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles; well above the long hold and the gaps
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 20;    // extra idle wait in wait_quiet, in cycles

  // record shapes
  localparam int REC_GOOD       = 0;
  localparam int REC_BAD_HEADER = 1;
  localparam int REC_BAD_BIN    = 2;
  localparam int REC_NOISE      = 3;

  // sample content
  localparam int FILL_UNIFORM = 0;
  localparam int FILL_SPARSE  = 1;  // mostly below threshold, now and then a pulse
  localparam int FILL_EXTREME = 2;  // only 0 or full scale

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] peak;
    logic [CHARGE_W-1:0] charge;
    logic [POS_W-1:0]    peak_bin;
    logic [SAMPLE_W-1:0] baseline;
    logic [TAG_W-1:0]    time_tag;
    logic [TYPE_W-1:0]   trigger_type;
    logic                calib_flag;
    logic                coincidence;
    logic                status;
    logic                last;
  } summary_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } pair_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ptpc_in_if  pairs();
  ptpc_out_if results();

  pulse_trace_peak_charge_trigger_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pairs     (pairs),
    .results   (results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Record model: own copy of the registers and the per-record accumulators
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]     win_cfg [NUM_CH];
  logic [SAMPLE_W-1:0]  thr_cfg [NUM_STRETCH];

  logic [POS_W-1:0]     rec_pos;     // 0 = header due, p = bin p-1 due
  logic                 rec_bad;
  logic [SAMPLE_W-1:0]  peak_v     [NUM_CH];
  logic [POS_W-1:0]     peak_at    [NUM_CH];
  logic [CHARGE_W-1:0]  charge_acc [NUM_CH];
  logic [SAMPLE_W-1:0]  base_v     [NUM_CH];
  logic [STRETCH_W-1:0] stretch    [NUM_STRETCH];
  logic                 coinc_seen;
  logic [TAG_W-1:0]     hdr_tag;
  logic [TYPE_W-1:0]    hdr_type;
  logic                 hdr_calib;

  summary_t channel_summaries[$];  // summaries still owed by the block
  pair_t    pair_queue[$];         // beats not yet offered

  int errors         = 0;
  int pairs_queued   = 0;
  int pairs_accepted = 0;

  // Fold one accepted pair into the record; at the record's final bin this
  // queues the four channel summaries.
  function automatic void fold_pair(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    logic [POS_W-1:0]    bin;
    logic [POS_W-1:0]    lo;
    logic [POS_W-1:0]    hi;
    int                  active;
    summary_t            r;
    if (rec_pos == 0) begin
      // header: stretch and coincidence restart, flags must both be set
      rec_bad    = !(a[FLAG_BIT] && b[FLAG_BIT]);
      coinc_seen = 1'b0;
      foreach (stretch[i]) stretch[i] = '0;
      if (!rec_bad) begin
        hdr_tag   = a[TAG_W-1:0];
        hdr_type  = b[TYPE_W-1:0];
        hdr_calib = b[CALIB_BIT];
      end
      rec_pos = POS_W'(1);
      return;
    end
    if (!rec_bad && (a[FLAG_BIT] || b[FLAG_BIT])) begin
      rec_bad = 1'b1;  // rest of the record is only counted
    end else if (!rec_bad) begin
      smp[0] = a[11:0];
      smp[1] = a[27:16];
      smp[2] = b[11:0];
      smp[3] = b[27:16];
      bin    = rec_pos - 1'b1;
      active = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        lo = win_cfg[ch][6:0];
        hi = win_cfg[ch][13:7];
        if (bin == 0) begin
          base_v[ch]     = smp[ch];
          peak_v[ch]     = smp[ch];
          peak_at[ch]    = '0;
          charge_acc[ch] = '0;
        end else if (smp[ch] > peak_v[ch]) begin
          peak_v[ch]  = smp[ch];   // strict compare keeps the first peak bin
          peak_at[ch] = bin;
        end
        if (lo <= bin && bin < hi) charge_acc[ch] = charge_acc[ch] + smp[ch];
        if (ch < NUM_STRETCH && bin != 0) begin
          if (smp[ch] > thr_cfg[ch]) begin
            stretch[ch] = STRETCH_W'(STRETCH_BINS);
            active++;
          end else if (stretch[ch] != 0) begin
            stretch[ch] = stretch[ch] - 1'b1;
            active++;
          end
        end
      end
      if (active == NUM_STRETCH) coinc_seen = 1'b1;
    end
    if (rec_pos < BINS_PER_RECORD) begin
      rec_pos = rec_pos + 1'b1;
      return;
    end
    rec_pos = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      r         = '0;
      r.channel = CH_W'(ch);
      r.status  = rec_bad;
      r.last    = (ch == NUM_CH - 1);
      if (!rec_bad) begin
        r.peak         = peak_v[ch];
        r.charge       = charge_acc[ch];
        r.peak_bin     = peak_at[ch];
        r.baseline     = base_v[ch];
        r.time_tag     = hdr_tag;
        r.trigger_type = hdr_type;
        r.calib_flag   = hdr_calib;
        r.coincidence  = coinc_seen;
      end
      channel_summaries.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: beats are taken at the rising edge
  // ---------------------------------------------------------------------------
  logic pair_taken = 1'b0;

  always @(posedge clk) begin : monitor
    summary_t want;
    if (rst) begin
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= pairs.valid && pairs.ready;
      if (pairs.valid && pairs.ready) begin
        fold_pair(pairs.word_a, pairs.word_b);
        pairs_accepted++;
      end
      if (results.valid && results.ready) begin
        if (channel_summaries.size() == 0) begin
          errors++;
          $display("%0t: result beat expected none, got channel %0d", $time,
                   results.channel);
        end else begin
          want = channel_summaries.pop_front();
          check_field("channel",      want.channel,      results.channel);
          check_field("peak",         want.peak,         results.peak);
          check_field("charge",       want.charge,       results.charge);
          check_field("peak_bin",     want.peak_bin,     results.peak_bin);
          check_field("baseline",     want.baseline,     results.baseline);
          check_field("time_tag",     want.time_tag,     results.time_tag);
          check_field("trigger_type", want.trigger_type, results.trigger_type);
          check_field("calib_flag",   want.calib_flag,   results.calib_flag);
          check_field("coincidence",  want.coincidence,  results.coincidence);
          check_field("status",       want.status,       results.status);
          check_field("last",         want.last,         results.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pair driver: changes at the falling edge, holds a beat until it is taken
  // ---------------------------------------------------------------------------
  int in_gap_odds  = 0;  // 1-in-N chance of starting a gap; 0 = no gaps
  int out_gap_odds = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  logic want_long_hold = 1'b0;
  logic long_hold_done = 1'b0;

  always @(negedge clk) begin : pair_driver
    pair_t nxt;
    if (rst) begin
      pairs.valid  <= 1'b0;
      pairs.word_a <= '0;
      pairs.word_b <= '0;
    end else if (pairs.valid && !pair_taken) begin
      // beat still waiting for ready
    end else if (gap_left > 0) begin
      gap_left--;
      pairs.valid <= 1'b0;
    end else if (pair_queue.size() == 0) begin
      pairs.valid <= 1'b0;
    end else if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      gap_left = $urandom_range(0, 18);  // start a burst of idle cycles
      pairs.valid <= 1'b0;
    end else begin
      nxt = pair_queue.pop_front();
      pairs.valid  <= 1'b1;
      pairs.word_a <= nxt.a;
      pairs.word_b <= nxt.b;
    end
  end

  // Result sink: random stalls, plus one long hold so the block backs up and
  // stalls the final bin of a record while the sender keeps offering beats.
  always @(negedge clk) begin : result_sink
    if (rst) begin
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD - 1;
      results.ready <= 1'b0;
    end else if (out_gap_odds != 0 && $urandom_range(1, out_gap_odds) == 1) begin
      stall_left = $urandom_range(0, 18);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pairs.valid && pairs.ready) || (results.valid && results.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [SAMPLE_W-1:0] draw_sample(int fill);
    case (fill)
      FILL_SPARSE:  return ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom_range(300, 4095))
                                                       : SAMPLE_W'($urandom_range(0, 250));
      FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:      return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One record of random content; junk bits outside the samples stay random.
  function automatic void queue_record(int kind, int fill);
    pair_t p;
    int    bad_at;
    bad_at = $urandom_range(1, BINS_PER_RECORD);
    for (int pos = 0; pos < RECORD_LEN; pos++) begin
      p.a = $urandom;
      p.b = $urandom;
      if (kind != REC_NOISE) begin
        if (pos == 0) begin
          p.a[FLAG_BIT] = 1'b1;
          p.b[FLAG_BIT] = 1'b1;
          if (kind == REC_BAD_HEADER) begin
            case ($urandom_range(0, 2))
              0:       p.a[FLAG_BIT] = 1'b0;
              1:       p.b[FLAG_BIT] = 1'b0;
              default: begin
                p.a[FLAG_BIT] = 1'b0;
                p.b[FLAG_BIT] = 1'b0;
              end
            endcase
          end
        end else begin
          p.a[FLAG_BIT] = 1'b0;
          p.b[FLAG_BIT] = 1'b0;
          p.a[11:0]  = draw_sample(fill);
          p.a[27:16] = draw_sample(fill);
          p.b[11:0]  = draw_sample(fill);
          p.b[27:16] = draw_sample(fill);
          if (kind == REC_BAD_BIN && pos == bad_at) begin
            case ($urandom_range(0, 2))
              0:       p.a[FLAG_BIT] = 1'b1;
              1:       p.b[FLAG_BIT] = 1'b1;
              default: begin
                p.a[FLAG_BIT] = 1'b1;
                p.b[FLAG_BIT] = 1'b1;
              end
            endcase
          end
        end
      end
      pair_queue.push_back(p);
      pairs_queued++;
    end
  endfunction

  function automatic void queue_random_records(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      case (roll)
        0:       queue_record(REC_BAD_HEADER, $urandom_range(0, 2));
        1:       queue_record(REC_BAD_BIN,    $urandom_range(0, 2));
        2:       queue_record(REC_NOISE,      FILL_UNIFORM);
        default: queue_record(REC_GOOD,       $urandom_range(0, 2));
      endcase
    end
  endfunction

  // Directed record: every bin carries the same pair; a nonzero bad_at sets
  // the flag of word b at that position.
  function automatic void queue_fixed_record(logic [WORD_W-1:0] ha, logic [WORD_W-1:0] hb,
                                             logic [WORD_W-1:0] ba, logic [WORD_W-1:0] bb,
                                             int bad_at);
    pair_t p;
    for (int pos = 0; pos < RECORD_LEN; pos++) begin
      p.a = (pos == 0) ? ha : ba;
      p.b = (pos == 0) ? hb : bb;
      if (pos != 0 && pos == bad_at) p.b[FLAG_BIT] = 1'b1;
      pair_queue.push_back(p);
      pairs_queued++;
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_WINDOW_CH3) win_cfg[idx[CH_W-1:0]] = val;
    else thr_cfg[CH_W'(idx - REG_THRESHOLD_CH0)] = val[SAMPLE_W-1:0];
  endtask

  task automatic write_config(logic [WIN_W-1:0] w0, logic [WIN_W-1:0] w1,
                              logic [WIN_W-1:0] w2, logic [WIN_W-1:0] w3,
                              logic [CFG_DATA_W-1:0] t0, logic [CFG_DATA_W-1:0] t1,
                              logic [CFG_DATA_W-1:0] t2);
    write_reg(REG_WINDOW_CH0, w0);
    write_reg(REG_WINDOW_CH1, w1);
    write_reg(REG_WINDOW_CH2, w2);
    write_reg(REG_WINDOW_CH3, w3);
    write_reg(REG_THRESHOLD_CH0, t0);
    write_reg(REG_THRESHOLD_CH1, t1);
    write_reg(REG_THRESHOLD_CH2, t2);
  endtask

  // Windows mostly inside the record (bits 13:7 end, 6:0 first), sometimes any
  // 14-bit value; thresholds over all of 14 bits or near typical sample levels.
  task automatic write_random_config();
    logic [WIN_W-1:0]      w;
    logic [CFG_DATA_W-1:0] t;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      w[6:0]  = POS_W'($urandom_range(0, 72));
      w[13:7] = POS_W'($urandom_range(0, 72));
      if ($urandom_range(0, 3) == 0) w = WIN_W'($urandom);
      write_reg(CFG_IDX_W'(REG_WINDOW_CH0 + ch), w);
    end
    for (int ch = 0; ch < NUM_STRETCH; ch++) begin
      t = $urandom_range(0, 1) ? CFG_DATA_W'($urandom)
                               : CFG_DATA_W'($urandom_range(200, 2500));
      write_reg(CFG_IDX_W'(REG_THRESHOLD_CH0 + ch), t);
    end
  endtask

  // Idle means every queued pair taken and every summary delivered; the extra
  // idle wait then adds a margin before a register changes.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pairs_accepted != pairs_queued || channel_summaries.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_WINDOW_CH0;
    cfg_data      = '0;

    // model state after reset
    win_cfg[0] = WINDOW_RST_WIDE;
    win_cfg[1] = WINDOW_RST_WIDE;
    win_cfg[2] = WINDOW_RST_WIDE;
    win_cfg[3] = WINDOW_RST_CH3;
    thr_cfg[0] = THRESH_RST_CH0;
    thr_cfg[1] = THRESH_RST_CH1;
    thr_cfg[2] = THRESH_RST_CH2;
    rec_pos    = '0;
    rec_bad    = 1'b0;
    coinc_seen = 1'b0;
    hdr_tag    = '0;
    hdr_type   = '0;
    hdr_calib  = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      peak_v[ch]     = '0;
      peak_at[ch]    = '0;
      charge_acc[ch] = '0;
      base_v[ch]     = '0;
    end
    foreach (stretch[i]) stretch[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed records at reset settings: full-scale header and samples,
    // then a record whose final bin is bad.
    in_gap_odds  = 10;
    out_gap_odds = 10;
    @(posedge clk);
    queue_fixed_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    queue_fixed_record(32'hC0DE_5EED, 32'h8000_0025, 32'h0123_0456, 32'h0789_0ABC,
                       BINS_PER_RECORD);
    wait_quiet();

    // Windows of bin 0 only, last bin only, exactly the record, bins 1..68;
    // full-scale thresholds so no channel ever fires.
    write_config((14'd1 << 7) | 14'd0, (14'd69 << 7) | 14'd68,
                 (14'd70 << 7) | 14'd0, (14'd69 << 7) | 14'd1,
                 14'h3FFF, 14'h0FFF, 14'h0FFF);
    in_gap_odds  = 0;
    out_gap_odds = 4;
    @(posedge clk);
    queue_random_records(1);
    wait_quiet();

    // back-pressure: sender streams without gaps while the sink holds off
    write_random_config();
    in_gap_odds    = 0;
    out_gap_odds   = 8;
    want_long_hold = 1'b1;
    @(posedge clk);
    queue_random_records(2);
    wait_quiet();

    // Last stretch without idling on either side. Extremes: full window, empty
    // window, all-ones window, inverted window; zero thresholds make each stretched
    // channel fire on any nonzero sample past bin 0.
    write_config(14'h3F80, 14'h0000, 14'h3FFF, (14'd10 << 7) | 14'd60,
                 14'h0000, 14'h0000, 14'h0000);
    in_gap_odds  = 0;
    out_gap_odds = 0;
    @(posedge clk);
    queue_random_records(1);
    wait_quiet();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
